>>> sv/arpc_pkg.sv
// ----------------------------------------------------------------------------
// ARP cache package
// Shared widths, codes, controller states and the command and status
// structures that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package arpc_pkg;

	localparam int ENTRIES = 32;
	localparam int IDX_W   = $clog2(ENTRIES);
	localparam int ADDR_W  = 32;
	localparam int MAC_W   = 48;
	localparam int LIFE_W  = 10;
	localparam int CODE_W  = 2;

	localparam logic [ADDR_W-1:0] BCAST_ADDR   = '1;
	localparam logic [MAC_W-1:0]  ALL_ONES_MAC = '1;
	localparam logic [LIFE_W-1:0] LIFETIME_RST = LIFE_W'(1000);

	typedef enum logic [CODE_W-1:0] {
		ACT_LEARN  = 2'd0,
		ACT_LOOKUP = 2'd1,
		ACT_TICK   = 2'd2,
		ACT_NONE   = 2'd3
	} act_t;

	typedef enum logic [CODE_W-1:0] {
		STS_DONE   = 2'd0,
		STS_FOUND  = 2'd1,
		STS_MISS   = 2'd2,
		STS_OFFNET = 2'd3
	} sts_t;

	typedef enum logic [CODE_W-1:0] {
		REG_LOCAL    = 2'd0,
		REG_MASK     = 2'd1,
		REG_GATEWAY  = 2'd2,
		REG_LIFETIME = 2'd3
	} reg_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_DRAIN,
		S_DONE
	} state_t;

	typedef struct packed {
		logic load;
		logic rd;
		logic commit;
	} cmd_t;

	typedef struct packed {
		logic need_scan;
		logic rd_last;
		logic out_full;
	} dp_sts_t;

endpackage

`default_nettype wire

>>> sv/arpc_ctrl.sv
// ----------------------------------------------------------------------------
// ARP cache controller
// Sequences one item at a time: accept, table scan and pipeline drain when the
// item needs the table, and commit of the table update and the result.
// ----------------------------------------------------------------------------
`default_nettype none

module arpc_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	output arpc_pkg::cmd_t         cmd,
	input  wire arpc_pkg::dp_sts_t sts
);
	import arpc_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					state_d = sts.need_scan ? S_SCAN : S_DONE;
				end
			end
			S_SCAN: begin
				if (sts.rd_last) begin
					state_d = S_DRAIN;
				end
			end
			S_DRAIN: begin
				state_d = S_DONE;
			end
			S_DONE: begin
				if (!sts.out_full) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_comb begin
		in_ready   = 1'b0;
		cmd.load   = 1'b0;
		cmd.rd     = 1'b0;
		cmd.commit = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			S_SCAN: begin
				cmd.rd = 1'b1;
			end
			S_DRAIN: begin
			end
			S_DONE: begin
				cmd.commit = !sts.out_full;
			end
			default: begin
			end
		endcase
	end

endmodule

`default_nettype wire

>>> sv/arpc_dp.sv
// ----------------------------------------------------------------------------
// ARP cache datapath
// Holds the address and MAC memories, the life counts, the scan
// accumulators and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module arpc_dp (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire arpc_pkg::cmd_t               cmd,
	output arpc_pkg::dp_sts_t                 sts,
	input  wire arpc_pkg::act_t               in_act,
	input  wire logic [arpc_pkg::ADDR_W-1:0]  in_ip,
	input  wire logic [arpc_pkg::MAC_W-1:0]   in_mac,
	input  wire logic [arpc_pkg::ADDR_W-1:0]  local_addr,
	input  wire logic [arpc_pkg::ADDR_W-1:0]  subnet_mask,
	input  wire logic [arpc_pkg::ADDR_W-1:0]  gateway_addr,
	input  wire logic [arpc_pkg::LIFE_W-1:0]  lifetime,
	input  wire logic                         out_ready,
	output logic                              out_valid,
	output arpc_pkg::sts_t                    out_status,
	output logic [arpc_pkg::MAC_W-1:0]        out_mac,
	output logic [arpc_pkg::ADDR_W-1:0]       out_addr
);
	import arpc_pkg::*;

	logic [ADDR_W-1:0] addr_mem [ENTRIES];
	logic [MAC_W-1:0]  mac_mem  [ENTRIES];
	logic [LIFE_W-1:0] life_q   [ENTRIES];

	logic              in_onsub;
	logic [ADDR_W-1:0] in_res;

	act_t              act_q;
	logic [ADDR_W-1:0] key_q;
	logic [MAC_W-1:0]  mac_q;
	logic              onsub_q;

	logic [IDX_W-1:0]  rd_idx_q;
	logic              valid_s1;
	logic [IDX_W-1:0]  idx_s1;
	logic [ADDR_W-1:0] addr_s1;
	logic [MAC_W-1:0]  mac_s1;
	logic [LIFE_W-1:0] life_s1;

	logic              hit_q;
	logic [IDX_W-1:0]  hit_idx_q;
	logic [MAC_W-1:0]  hit_mac_q;
	logic              free_q;
	logic [IDX_W-1:0]  free_idx_q;
	logic              old_q;
	logic [IDX_W-1:0]  old_idx_q;
	logic [LIFE_W-1:0] old_life_q;

	logic              live_s1;
	logic              match_s1;
	logic [IDX_W-1:0]  pick;
	logic              wr_en;
	logic              tick_en;

	sts_t              res_status;
	logic [MAC_W-1:0]  res_mac;
	logic [ADDR_W-1:0] res_addr;

	logic              out_valid_q;
	sts_t              out_status_q;
	logic [MAC_W-1:0]  out_mac_q;
	logic [ADDR_W-1:0] out_addr_q;

	assign in_onsub = (in_ip & subnet_mask) == (local_addr & subnet_mask);
	assign in_res   = in_onsub ? in_ip : gateway_addr;

	assign sts.need_scan = (in_act == ACT_LEARN && in_onsub)
		|| (in_act == ACT_LOOKUP && in_res != BCAST_ADDR);
	assign sts.rd_last   = rd_idx_q == IDX_W'(ENTRIES - 1);
	assign sts.out_full  = out_valid_q && !out_ready;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			key_q   <= (in_act == ACT_LOOKUP) ? in_res : in_ip;
			mac_q   <= in_mac;
			onsub_q <= in_onsub;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q    <= ACT_NONE;
			rd_idx_q <= '0;
			valid_s1 <= 1'b0;
		end else begin
			if (cmd.load) begin
				act_q <= in_act;
			end
			if (cmd.load) begin
				rd_idx_q <= '0;
			end else if (cmd.rd && !sts.rd_last) begin
				rd_idx_q <= rd_idx_q + IDX_W'(1);
			end
			valid_s1 <= cmd.rd;
		end
	end

	// Memories: one write port for the learn, one registered read for the scan.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			addr_mem[pick] <= key_q;
			mac_mem[pick]  <= mac_q;
		end
		addr_s1 <= addr_mem[rd_idx_q];
		mac_s1  <= mac_mem[rd_idx_q];
		life_s1 <= life_q[rd_idx_q];
		idx_s1  <= rd_idx_q;
	end

	assign live_s1  = life_s1 != '0;
	assign match_s1 = addr_s1 == key_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q  <= 1'b0;
			free_q <= 1'b0;
			old_q  <= 1'b0;
		end else if (cmd.load) begin
			hit_q  <= 1'b0;
			free_q <= 1'b0;
			old_q  <= 1'b0;
		end else if (valid_s1 && !hit_q) begin
			if (live_s1 && match_s1) begin
				hit_q <= 1'b1;
			end
			if (!live_s1) begin
				free_q <= 1'b1;
			end
			if (live_s1 && !match_s1 && (!old_q || life_s1 < old_life_q)) begin
				old_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && !hit_q) begin
			if (live_s1 && match_s1) begin
				hit_idx_q <= idx_s1;
				hit_mac_q <= mac_s1;
			end
			if (!live_s1) begin
				free_idx_q <= idx_s1;
			end
			if (live_s1 && !match_s1 && (!old_q || life_s1 < old_life_q)) begin
				old_idx_q  <= idx_s1;
				old_life_q <= life_s1;
			end
		end
	end

	// When no slot is free and none matches, every slot is live, so the
	// oldest one is set; a full table at equal life resolves to slot zero.
	always_comb begin
		if (hit_q) begin
			pick = hit_idx_q;
		end else if (free_q) begin
			pick = free_idx_q;
		end else if (old_q) begin
			pick = old_idx_q;
		end else begin
			pick = '0;
		end
	end

	assign wr_en   = cmd.commit && act_q == ACT_LEARN && onsub_q;
	assign tick_en = cmd.commit && act_q == ACT_TICK;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ENTRIES; i++) begin
				life_q[i] <= '0;
			end
		end else if (tick_en) begin
			for (int i = 0; i < ENTRIES; i++) begin
				if (life_q[i] != '0) begin
					life_q[i] <= life_q[i] - LIFE_W'(1);
				end
			end
		end else if (wr_en) begin
			life_q[pick] <= lifetime;
		end
	end

	always_comb begin
		res_status = STS_DONE;
		res_mac    = '0;
		res_addr   = '0;
		case (act_q)
			ACT_LEARN: begin
				res_status = onsub_q ? STS_DONE : STS_OFFNET;
			end
			ACT_LOOKUP: begin
				res_addr = key_q;
				if (key_q == BCAST_ADDR) begin
					res_status = STS_FOUND;
					res_mac    = ALL_ONES_MAC;
				end else if (hit_q) begin
					res_status = STS_FOUND;
					res_mac    = hit_mac_q;
				end else begin
					res_status = STS_MISS;
				end
			end
			ACT_TICK: begin
				res_status = STS_DONE;
			end
			default: begin
				res_status = STS_DONE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			out_status_q <= res_status;
			out_mac_q    <= res_mac;
			out_addr_q   <= res_addr;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_status = out_status_q;
	assign out_mac    = out_mac_q;
	assign out_addr   = out_addr_q;

endmodule

`default_nettype wire

>>> sv/arp_cache_table.sv
// A learn or lookup that needs the table goes from the accepted beat through
// the scan of every slot, the drain state and the commit to the result beat;
// the rest go straight to the commit, which waits while the output stalls. The
// next beat is taken once the result is registered, so items pass one at a time.
// The rate is set by the scan, which reads one table slot per cycle through
// the single read port of the address and MAC memories.
// Reset clears all life counts at once and restores the register defaults.
// ----------------------------------------------------------------------------
// ARP cache table
// Maps IPv4 addresses to MAC addresses with per-entry aging, subnet and
// gateway handling, and a broadcast answer for the all-ones address.
// ----------------------------------------------------------------------------
`default_nettype none

module arp_cache_table (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         cfg_wr_en,
	input  wire logic [arpc_pkg::CODE_W-1:0]  cfg_index,
	input  wire logic [arpc_pkg::ADDR_W-1:0]  cfg_data,
	input  wire logic                         s_tvalid,
	output logic                              s_tready,
	input  wire logic [79:0]                  s_tdata,   // ip_addr[31:0], mac_addr[79:32]
	input  wire logic [1:0]                   s_tuser,   // action[1:0]
	output logic                              m_tvalid,
	input  wire logic                         m_tready,
	output logic [79:0]                       m_tdata,   // mac_out[47:0], resolved_addr[79:48]
	output logic [1:0]                        m_tuser    // status[1:0]
);
	import arpc_pkg::*;

	logic [ADDR_W-1:0] local_addr_q;
	logic [ADDR_W-1:0] subnet_mask_q;
	logic [ADDR_W-1:0] gateway_addr_q;
	logic [LIFE_W-1:0] lifetime_q;

	cmd_t              cmd;
	dp_sts_t           sts;
	sts_t              out_status;
	logic [MAC_W-1:0]  out_mac;
	logic [ADDR_W-1:0] out_addr;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			local_addr_q   <= '0;
			subnet_mask_q  <= '0;
			gateway_addr_q <= '0;
			lifetime_q     <= LIFETIME_RST;
		end else if (cfg_wr_en) begin
			case (reg_t'(cfg_index))
				REG_LOCAL:    local_addr_q   <= cfg_data;
				REG_MASK:     subnet_mask_q  <= cfg_data;
				REG_GATEWAY:  gateway_addr_q <= cfg_data;
				REG_LIFETIME: lifetime_q     <= cfg_data[LIFE_W-1:0];
				default: begin
				end
			endcase
		end
	end

	arpc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.cmd      (cmd),
		.sts      (sts)
	);

	arpc_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.in_act       (act_t'(s_tuser)),
		.in_ip        (s_tdata[31:0]),
		.in_mac       (s_tdata[79:32]),
		.local_addr   (local_addr_q),
		.subnet_mask  (subnet_mask_q),
		.gateway_addr (gateway_addr_q),
		.lifetime     (lifetime_q),
		.out_ready    (m_tready),
		.out_valid    (m_tvalid),
		.out_status   (out_status),
		.out_mac      (out_mac),
		.out_addr     (out_addr)
	);

	assign m_tdata = {out_addr, out_mac};
	assign m_tuser = out_status;

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("second beat accepted while an item is in progress");

	a_no_ready_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rd |-> !s_tready)
		else $error("input ready during the table scan");

	a_commit_shows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> m_tvalid)
		else $error("committed result not presented");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> !(m_tvalid && !m_tready))
		else $error("result register overwritten while stalled");

endmodule

`default_nettype wire

>>> verif/arp_cache_table_chk.sv
// ----------------------------------------------------------------------------
// ARP cache table checker
// Follows the register writes and both stream channels. It keeps its own copy
// of the table and registers, works out the answer each request beat will
// give, and compares every result beat with the oldest answer awaited.
// ----------------------------------------------------------------------------
module arp_cache_table_chk (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_wr_en,
	input  wire logic [arpc_pkg::CODE_W-1:0]   cfg_index,
	input  wire logic [arpc_pkg::ADDR_W-1:0]   cfg_data,
	input  wire logic                          s_tvalid,
	input  wire logic                          s_tready,
	input  wire logic [79:0]                   s_tdata,   // ip_addr[31:0], mac_addr[79:32]
	input  wire logic [1:0]                    s_tuser,   // action[1:0]
	input  wire logic                          m_tvalid,
	input  wire logic                          m_tready,
	input  wire logic [79:0]                   m_tdata,   // mac_out[47:0], resolved_addr[79:48]
	input  wire logic [1:0]                    m_tuser,   // status[1:0]
	output int                                 outstanding,
	output int                                 fail_count
);
	import arpc_pkg::*;

	typedef struct packed {
		sts_t              status;
		logic [MAC_W-1:0]  mac;
		logic [ADDR_W-1:0] addr;
	} arp_answer_t;

	logic [ADDR_W-1:0] own_local;
	logic [ADDR_W-1:0] own_mask;
	logic [ADDR_W-1:0] own_gateway;
	logic [LIFE_W-1:0] own_lifetime;

	logic [ADDR_W-1:0] slot_addr [ENTRIES];
	logic [MAC_W-1:0]  slot_mac  [ENTRIES];
	logic [LIFE_W-1:0] slot_life [ENTRIES];

	arp_answer_t awaited_answers [$];

	initial fail_count = 0;

	function automatic logic on_subnet(input logic [ADDR_W-1:0] a);
		return (a & own_mask) == (own_local & own_mask);
	endfunction

	task automatic mismatch(input string field, input logic [79:0] seen,
			input logic [79:0] wanted);
		$display("ERROR at %0t: %s is %h, expected %h", $time, field, seen, wanted);
		fail_count++;
	endtask

	task automatic resolve_request(input act_t act, input logic [ADDR_W-1:0] ip,
			input logic [MAC_W-1:0] mac, output arp_answer_t ans);
		int hit;
		int free_slot;
		int oldest;
		int pick;
		logic [LIFE_W-1:0] least;
		logic [ADDR_W-1:0] target;
		ans.status = STS_DONE;
		ans.mac = '0;
		ans.addr = '0;
		hit = -1;
		free_slot = -1;
		oldest = -1;
		least = '0;
		case (act)
			ACT_LEARN: begin
				if (!on_subnet(ip)) begin
					ans.status = STS_OFFNET;
				end else begin
					// First live match wins, then the highest free slot, then the
					// live slot with the least life left, lowest index on a tie.
					for (int i = 0; i < ENTRIES; i++) begin
						if (slot_life[i] != '0) begin
							if (hit < 0 && slot_addr[i] == ip)
								hit = i;
							if (oldest < 0 || slot_life[i] < least) begin
								least = slot_life[i];
								oldest = i;
							end
						end else begin
							free_slot = i;
						end
					end
					if (hit >= 0)
						pick = hit;
					else if (free_slot >= 0)
						pick = free_slot;
					else
						pick = oldest;
					slot_addr[pick] = ip;
					slot_mac[pick] = mac;
					slot_life[pick] = own_lifetime;
				end
			end
			ACT_LOOKUP: begin
				target = on_subnet(ip) ? ip : own_gateway;
				ans.addr = target;
				if (target == BCAST_ADDR) begin
					ans.status = STS_FOUND;
					ans.mac = ALL_ONES_MAC;
				end else begin
					ans.status = STS_MISS;
					for (int i = 0; i < ENTRIES; i++) begin
						if (ans.status == STS_MISS && slot_life[i] != '0
								&& slot_addr[i] == target) begin
							ans.status = STS_FOUND;
							ans.mac = slot_mac[i];
						end
					end
				end
			end
			ACT_TICK: begin
				for (int i = 0; i < ENTRIES; i++)
					if (slot_life[i] != '0)
						slot_life[i] = slot_life[i] - 1'b1;
			end
			default: ;
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		arp_answer_t want;
		arp_answer_t got;
		if (!arst_n) begin
			own_local = '0;
			own_mask = '0;
			own_gateway = '0;
			own_lifetime = LIFETIME_RST;
			for (int i = 0; i < ENTRIES; i++)
				slot_life[i] = '0;
			awaited_answers.delete();
			outstanding <= 0;
		end else begin
			if (cfg_wr_en) begin
				case (reg_t'(cfg_index))
					REG_LOCAL:    own_local = cfg_data;
					REG_MASK:     own_mask = cfg_data;
					REG_GATEWAY:  own_gateway = cfg_data;
					REG_LIFETIME: own_lifetime = cfg_data[LIFE_W-1:0];
					default: ;
				endcase
			end
			if (m_tvalid && m_tready) begin
				got.status = sts_t'(m_tuser);
				got.mac = m_tdata[47:0];
				got.addr = m_tdata[79:48];
				if (awaited_answers.size() == 0) begin
					mismatch("unexpected result beat", m_tdata, '0);
				end else begin
					want = awaited_answers.pop_front();
					if (got.status !== want.status)
						mismatch("status", 80'(got.status), 80'(want.status));
					if (got.mac !== want.mac)
						mismatch("mac_out", 80'(got.mac), 80'(want.mac));
					if (got.addr !== want.addr)
						mismatch("resolved_addr", 80'(got.addr), 80'(want.addr));
				end
			end
			if (s_tvalid && s_tready) begin
				resolve_request(act_t'(s_tuser), s_tdata[31:0], s_tdata[79:32], want);
				awaited_answers.push_back(want);
			end
			outstanding <= awaited_answers.size();
		end
	end

endmodule

>>> verif/arp_cache_table_tb.sv
// ----------------------------------------------------------------------------
// ARP cache table testbench
// Drives learn, lookup, tick and no-action requests through several register settings,
// with random gaps on both streams and one long output stall, and leaves the
// checking to the checker instantiated beside the block.
// ----------------------------------------------------------------------------
module arp_cache_table_tb;

	import arpc_pkg::*;

	localparam int LIMIT = 400000;

	logic                clk;
	logic                arst_n;
	logic                cfg_wr_en;
	logic [CODE_W-1:0]   cfg_index;
	logic [ADDR_W-1:0]   cfg_data;
	logic                s_tvalid;
	logic                s_tready;
	logic [79:0]         s_tdata;
	logic [1:0]          s_tuser;
	logic                m_tvalid;
	logic                m_tready;
	logic [79:0]         m_tdata;
	logic [1:0]          m_tuser;

	int outstanding;
	int fail_count;
	int cycle_count = 0;

	bit tx_gaps = 1'b1;
	bit rx_gaps = 1'b1;
	bit long_hold = 1'b0;

	logic [ADDR_W-1:0] net_local;
	logic [ADDR_W-1:0] net_mask;

	arp_cache_table DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	arp_cache_table_chk CHK (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser),
		.outstanding (outstanding),
		.fail_count  (fail_count)
	);

	initial clk = 1'b0;
	always #6 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	// Result side: short random stalls, and one long hold when asked for.
	initial begin
		m_tready = 1'b0;
		forever begin
			if (long_hold) begin
				m_tready <= 1'b0;
				repeat (300) @(posedge clk);
				long_hold = 1'b0;
			end else if (rx_gaps && $urandom_range(0, 4) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 3)) @(posedge clk);
			end else begin
				m_tready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	function automatic logic [ADDR_W-1:0] host_ip(input int host);
		return (net_local & net_mask) | (ADDR_W'(host) & ~net_mask);
	endfunction

	function automatic logic [ADDR_W-1:0] pick_ip();
		int r;
		r = $urandom_range(0, 99);
		if (r < 80)
			return host_ip($urandom_range(0, 47));
		else if (r < 85)
			return BCAST_ADDR;
		else
			return $urandom;
	endfunction

	function automatic logic [MAC_W-1:0] rand_mac();
		return MAC_W'({$urandom, $urandom});
	endfunction

	task automatic offer_request(input act_t act, input logic [ADDR_W-1:0] ip,
			input logic [MAC_W-1:0] mac);
		if (tx_gaps && $urandom_range(0, 4) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= act;
		s_tdata <= {mac, ip};
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic settle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic load_registers(input logic [ADDR_W-1:0] loc, input logic [ADDR_W-1:0] mask,
			input logic [ADDR_W-1:0] gw, input logic [ADDR_W-1:0] life);
		cfg_wr_en <= 1'b1;
		cfg_index <= REG_LOCAL;
		cfg_data <= loc;
		@(posedge clk);
		cfg_index <= REG_MASK;
		cfg_data <= mask;
		@(posedge clk);
		cfg_index <= REG_GATEWAY;
		cfg_data <= gw;
		@(posedge clk);
		cfg_index <= REG_LIFETIME;
		cfg_data <= life;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		net_local = loc;
		net_mask = mask;
	endtask

	task automatic random_phase(input int count);
		int sent;
		int base;
		int r;
		sent = 0;
		while (sent < count) begin
			r = $urandom_range(0, 99);
			if (r < 2) begin
				// A run of distinct learns with no tick fills the table so that
				// the oldest-entry replacement is exercised.
				base = $urandom_range(0, 47);
				for (int i = 0; i < 36; i++)
					offer_request(ACT_LEARN, host_ip((base + i) % 48), rand_mac());
				sent += 36;
			end else begin
				r = $urandom_range(0, 99);
				if (r < 40)
					offer_request(ACT_LEARN, pick_ip(), rand_mac());
				else if (r < 80)
					offer_request(ACT_LOOKUP, pick_ip(), rand_mac());
				else if (r < 95)
					offer_request(ACT_TICK, $urandom, rand_mac());
				else
					offer_request(ACT_NONE, $urandom, rand_mac());
				sent++;
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_index = REG_LOCAL;
		cfg_data = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = ACT_NONE;
		net_local = '0;
		net_mask = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Register defaults: every address is on the subnet.
		offer_request(ACT_LEARN, 32'h0000_0000, 48'h0);
		offer_request(ACT_LEARN, BCAST_ADDR, ALL_ONES_MAC);
		offer_request(ACT_LOOKUP, 32'h0000_0000, 48'h0);
		offer_request(ACT_LOOKUP, BCAST_ADDR, 48'h0);
		offer_request(ACT_LOOKUP, 32'h5A5A_5A5A, ALL_ONES_MAC);
		offer_request(ACT_TICK, 32'h0, 48'h0);
		offer_request(ACT_NONE, BCAST_ADDR, ALL_ONES_MAC);
		settle();

		// Upper data bits on the lifetime write are dropped, giving 1023.
		load_registers(32'h0A01_0001, 32'hFFFF_FF00, 32'h0A01_0005, 32'hFFFF_FFFF);
		offer_request(ACT_LEARN, 32'h0B00_0000, 48'h1234_5678_9ABC);
		offer_request(ACT_LEARN, 32'h0A01_0005, 48'hA5A5_A5A5_A5A5);
		offer_request(ACT_LOOKUP, 32'hC0A8_0001, 48'h0);
		offer_request(ACT_LOOKUP, 32'h0A01_0005, 48'h0);
		settle();

		// A lowered lifetime must leave the older entry with its long life.
		load_registers(32'h0A01_0001, 32'hFFFF_FF00, 32'h0A01_0005, 32'd2);
		offer_request(ACT_LEARN, 32'h0A01_0006, 48'h5A5A_5A5A_5A5A);
		offer_request(ACT_TICK, 32'h0, 48'h0);
		offer_request(ACT_TICK, 32'h0, 48'h0);
		offer_request(ACT_LOOKUP, 32'h0A01_0006, 48'h0);
		offer_request(ACT_LOOKUP, 32'h0A01_0005, 48'h0);
		settle();

		// A zero lifetime writes the entry but leaves it dead.
		load_registers(32'h0A01_0001, 32'hFFFF_FF00, BCAST_ADDR, 32'd0);
		offer_request(ACT_LEARN, 32'h0A01_0007, 48'h0F0F_0F0F_0F0F);
		offer_request(ACT_LOOKUP, 32'h0A01_0007, 48'h0);
		offer_request(ACT_LOOKUP, 32'h0102_0304, 48'h0);
		settle();

		load_registers(32'h0A01_0001, 32'hFFFF_FF00, 32'h0A01_0003, $urandom_range(4, 40));
		random_phase(80);
		long_hold = 1'b1;
		random_phase(120);
		settle();

		load_registers(32'hC0A8_0000 | $urandom_range(0, 65535), 32'hFFFF_0000,
			32'h0808_0808, 32'd1);
		random_phase(200);
		settle();

		load_registers($urandom, 32'h0000_0000, $urandom, 32'd1023);
		random_phase(200);
		settle();

		load_registers($urandom, 32'hFFFF_FFFF, $urandom, $urandom_range(1, 1023));
		random_phase(150);
		settle();

		tx_gaps = 1'b0;
		rx_gaps = 1'b0;
		load_registers(32'h0A01_0001, 32'hFFFF_FFC0, 32'h0A01_0002, $urandom_range(2, 60));
		random_phase(200);
		settle();

		repeat (40) @(posedge clk);
		if (fail_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

>>> filelist.f
sv/arpc_pkg.sv
sv/arpc_ctrl.sv
sv/arpc_dp.sv
sv/arp_cache_table.sv
verif/arp_cache_table_chk.sv
verif/arp_cache_table_tb.sv
